### rtl/core/irfew_pkg.sv
// ----------------------------------------------------------------------------
// irfew_pkg
// Types and constants shared by the exponential weighting block.
// ----------------------------------------------------------------------------
package irfew_pkg;

    localparam int SampleW  = 16;
    localparam int FactorW  = 32;
    localparam int TimeW    = 32;
    localparam int BinW     = 16;
    localparam int WeightW  = 32;
    localparam int CumW     = 48;
    localparam int TwW      = 64;
    localparam int CfgW     = 32;
    localparam int CfgIdxW  = 2;
    localparam int FracW    = 16;
    localparam int MulW     = 33;
    localparam int ProdW    = 2 * MulW;

    localparam logic [FactorW-1:0] StartFactorRst = 32'h0001_0000;
    localparam logic [FactorW-1:0] StepFactorRst  = 32'h0001_0000;
    localparam logic [TimeW-1:0]   StartTimeRst   = '0;
    localparam logic [BinW-1:0]    BinWidthRst    = 16'd1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_FACTOR,
        CFG_STEP_FACTOR,
        CFG_START_TIME,
        CFG_BIN_WIDTH
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_MUL_F,
        ST_FIN
    } t_state;

endpackage

### rtl/core/irfew_in_if.sv
// ----------------------------------------------------------------------------
// irfew_in_if
// Sample channel: one response bin per beat.
// ----------------------------------------------------------------------------
interface irfew_in_if import irfew_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SampleW-1:0] irf_sample;
    logic               last_in_channel;

    modport source (output valid, output irf_sample, output last_in_channel, input ready);
    modport sink   (input valid, input irf_sample, input last_in_channel, output ready);
endinterface

### rtl/core/irfew_out_if.sv
// ----------------------------------------------------------------------------
// irfew_out_if
// Result channel: weighted values and running sums, one beat per bin.
// ----------------------------------------------------------------------------
interface irfew_out_if import irfew_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [WeightW-1:0] weighted;
    logic        [CumW-1:0]    cum_weighted;
    logic signed [TwW-1:0]     time_weighted;
    logic signed [TwW-1:0]     cum_time_weighted;
    logic                     saturated;

    modport source (output valid, output weighted, output cum_weighted,
                    output time_weighted, output cum_time_weighted,
                    output saturated, input ready);
    modport sink   (input valid, input weighted, input cum_weighted,
                    input time_weighted, input cum_time_weighted,
                    input saturated, output ready);
endinterface

### rtl/core/irfew_mul.sv
// ----------------------------------------------------------------------------
// irfew_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module irfew_mul import irfew_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [MulW-1:0]  i_a,
    input  logic signed [MulW-1:0]  i_b,
    output logic signed [ProdW-1:0] o_prod
);

    logic signed [ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/irf_exponential_weighting.sv
// ----------------------------------------------------------------------------
// irf_exponential_weighting
// Exponentially weighted prefix sums of an instrument response.
//
// Samples arrive on i_in_ch one bin per beat, channel after channel; the bin
// flagged last_in_channel closes a channel and the next one restarts factor
// and time from the configured start values and clears both sums. Each input
// beat gives exactly one result beat on o_out_ch. Configuration is to be
// written through i_cfg_we / i_cfg_idx / i_cfg_data only while the block is
// idle; the block does not enforce this. Start factor and start time apply
// from the next channel start; step factor and bin width are read every bin.
// One registered multiplier is used three times per bin (sample*factor,
// weighted*time, factor*step); ST_FIN writes the result register and
// advances factor and time. i_in_ch.ready is high only between bins.
// A result waits in the output register while the receiver stalls; the next
// bin is taken meanwhile and completes once the register is free.
// Synchronous reset restores the register defaults, drops any result and
// marks the next bin as a channel start.
// ----------------------------------------------------------------------------
module irf_exponential_weighting import irfew_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    irfew_in_if.sink           i_in_ch,
    irfew_out_if.source        o_out_ch
);

    t_state r_state, n_state;

    logic [FactorW-1:0]       r_start_factor;
    logic [FactorW-1:0]       r_step_factor;
    logic [TimeW-1:0]         r_start_time;
    logic [BinW-1:0]          r_bin_width;

    logic [FactorW-1:0]       r_factor;
    logic signed [TimeW-1:0]  r_time;
    logic [CumW-1:0]          r_sum_w;
    logic signed [TwW-1:0]    r_sum_tw;
    logic                     r_at_start;
    logic                     r_last;
    logic [WeightW-1:0]       r_w;
    logic signed [TwW-1:0]    r_tw;
    logic                     r_clip;

    logic                     r_out_valid;
    logic [WeightW-1:0]       r_o_w;
    logic [CumW-1:0]          r_o_cw;
    logic signed [TwW-1:0]    r_o_tw;
    logic signed [TwW-1:0]    r_o_ctw;
    logic                     r_o_sat;

    logic signed [MulW-1:0]   mul_a, mul_b;
    logic signed [ProdW-1:0]  prod;

    logic                     in_ready, in_fire, fin_go;
    logic [FactorW-1:0]       factor_sel;
    logic [WeightW-1:0]       w_now;
    logic [CumW:0]            cw_sum;
    logic [CumW-1:0]          n_sum_w;
    logic                     cw_clip;
    logic signed [TwW-1:0]    tw_now;
    logic [TwW:0]             ctw_sum;
    logic signed [TwW-1:0]    n_sum_tw;
    logic                     ctw_clip;
    logic [CumW-1:0]          nf_full;
    logic [FactorW-1:0]       n_factor;
    logic [TimeW:0]           nt_sum;
    logic signed [TimeW-1:0]  n_time;

    irfew_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_factor <= StartFactorRst;
            r_step_factor  <= StepFactorRst;
            r_start_time   <= StartTimeRst;
            r_bin_width    <= BinWidthRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_FACTOR: r_start_factor <= i_cfg_data[FactorW-1:0];
                CFG_STEP_FACTOR:  r_step_factor  <= i_cfg_data[FactorW-1:0];
                CFG_START_TIME:   r_start_time   <= i_cfg_data[TimeW-1:0];
                CFG_BIN_WIDTH:    r_bin_width    <= i_cfg_data[BinW-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_MUL_T;
            ST_MUL_T: n_state = ST_MUL_F;
            ST_MUL_F: n_state = ST_FIN;
            ST_FIN:   if (fin_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        in_ready = (r_state == ST_IDLE);
        in_fire  = in_ready && i_in_ch.valid;
        fin_go   = (r_state == ST_FIN) && (!r_out_valid || o_out_ch.ready);
    end

    // shared multiplier operands
    always_comb begin
        factor_sel = r_at_start ? r_start_factor : r_factor;
        case (r_state)
            ST_IDLE: begin
                mul_a = signed'({1'b0, factor_sel});
                mul_b = signed'({{(MulW-SampleW){1'b0}}, i_in_ch.irf_sample});
            end
            ST_MUL_T: begin
                mul_a = signed'({1'b0, prod[FracW+WeightW-1:FracW]});
                mul_b = signed'({r_time[TimeW-1], r_time});
            end
            default: begin
                mul_a = signed'({1'b0, r_factor});
                mul_b = signed'({1'b0, r_step_factor});
            end
        endcase
    end

    // saturating arithmetic
    always_comb begin
        w_now    = prod[FracW+WeightW-1:FracW];
        cw_sum   = {1'b0, r_sum_w} + {{(CumW+1-WeightW){1'b0}}, w_now};
        cw_clip  = cw_sum[CumW];
        n_sum_w  = cw_clip ? {CumW{1'b1}} : cw_sum[CumW-1:0];

        tw_now   = prod[TwW-1:0];
        ctw_sum  = {r_sum_tw[TwW-1], r_sum_tw} + {tw_now[TwW-1], tw_now};
        ctw_clip = ctw_sum[TwW] != ctw_sum[TwW-1];
        if (!ctw_clip) begin
            n_sum_tw = ctw_sum[TwW-1:0];
        end else if (ctw_sum[TwW]) begin
            n_sum_tw = {1'b1, {(TwW-1){1'b0}}};
        end else begin
            n_sum_tw = {1'b0, {(TwW-1){1'b1}}};
        end

        nf_full  = prod[FracW+CumW-1:FracW];
        n_factor = (|nf_full[CumW-1:FactorW]) ? {FactorW{1'b1}} : nf_full[FactorW-1:0];

        nt_sum   = {r_time[TimeW-1], r_time} + {{(TimeW+1-BinW){1'b0}}, r_bin_width};
        n_time   = (nt_sum[TimeW] != nt_sum[TimeW-1]) ?
                   signed'({1'b0, {(TimeW-1){1'b1}}}) : signed'(nt_sum[TimeW-1:0]);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_at_start  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_at_start  <= r_last;
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_last <= i_in_ch.last_in_channel;
                    r_clip <= 1'b0;
                    if (r_at_start) begin
                        r_factor <= r_start_factor;
                        r_time   <= signed'(r_start_time);
                        r_sum_w  <= '0;
                        r_sum_tw <= '0;
                    end
                end
            end
            ST_MUL_T: begin
                r_w     <= w_now;
                r_sum_w <= n_sum_w;
                r_clip  <= cw_clip;
            end
            ST_MUL_F: begin
                r_tw     <= tw_now;
                r_sum_tw <= n_sum_tw;
                r_clip   <= r_clip | ctw_clip;
            end
            ST_FIN: begin
                if (fin_go) begin
                    r_o_w   <= r_w;
                    r_o_cw  <= r_sum_w;
                    r_o_tw  <= r_tw;
                    r_o_ctw <= r_sum_tw;
                    r_o_sat <= r_clip;
                    if (!r_last) begin
                        r_factor <= n_factor;
                        r_time   <= n_time;
                    end
                end
            end
            default: ;
        endcase
    end

    assign i_in_ch.ready              = in_ready;
    assign o_out_ch.valid             = r_out_valid;
    assign o_out_ch.weighted          = r_o_w;
    assign o_out_ch.cum_weighted      = r_o_cw;
    assign o_out_ch.time_weighted     = r_o_tw;
    assign o_out_ch.cum_time_weighted = r_o_ctw;
    assign o_out_ch.saturated         = r_o_sat;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == ST_MUL_T)
        else $error("accepted beat did not start the multiply sequence");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result register loaded outside the final step");

    a_weight_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL_T |-> prod[ProdW-1:FracW+WeightW] == '0)
        else $error("sample product exceeds the weighted range");

endmodule
